@@ rtl/core/pes_pkg.sv @@
`timescale 1ns / 1ps

package pes_pkg;

  // Strobes from the sequencer to the two element and answer memories.
  typedef struct packed {
    logic el_we;
    logic el_re;
    logic ans_we;
    logic ans_re;
  } pes_mem_ctl_t;

endpackage

@@ rtl/core/pes_if.sv @@
`timescale 1ns / 1ps

interface pes_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

interface pes_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] product;
  logic                         is_last_result;
  logic                         overflowed;

  modport source (output valid, output product, output is_last_result, output overflowed,
                  input ready);
  modport sink (input valid, input product, input is_last_result, input overflowed,
                output ready);
endinterface

@@ rtl/core/pes_mul.sv @@
`timescale 1ns / 1ps

module pes_mul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] result
);

  // Wide words are cut into two halves; the high-by-high partial product
  // lies entirely above the word and is skipped.
  localparam bit SPLIT = (W > 32);
  localparam int P     = SPLIT ? (W + 1) / 2 : W;
  localparam int STEPS = SPLIT ? 3 : 1;
  localparam logic [1:0] LAST_STEP = 2'(STEPS - 1);

  logic [W-1:0]   a_r;
  logic [W-1:0]   b_r;
  logic [2*P-1:0] a_ext;
  logic [2*P-1:0] b_ext;
  logic [P-1:0]   op_a;
  logic [P-1:0]   op_b;
  logic [2*P-1:0] pp;
  logic [2*P-1:0] prod_r;
  logic           shift_r;
  logic [W-1:0]   term;
  logic [W-1:0]   acc;
  logic [1:0]     step;
  logic           mul_on;
  logic           acc_on;
  logic           last_r;

  assign a_ext = (2*P)'(a_r);
  assign b_ext = (2*P)'(b_r);

  always_comb begin
    op_a = a_ext[P-1:0];
    op_b = b_ext[P-1:0];
    if (step == 2'd1) begin
      op_b = b_ext[2*P-1:P];
    end else if (step == 2'd2) begin
      op_a = a_ext[2*P-1:P];
    end
  end

  assign pp     = op_a * op_b;
  assign term   = shift_r ? W'(prod_r << P) : W'(prod_r);
  assign result = acc + term;
  assign done   = acc_on & last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_on <= 1'b0;
      acc_on <= 1'b0;
      last_r <= 1'b0;
      step   <= 2'd0;
    end else begin
      acc_on <= mul_on;
      last_r <= mul_on && (step == LAST_STEP);
      if (start) begin
        mul_on <= 1'b1;
        step   <= 2'd0;
      end else if (mul_on) begin
        step <= step + 2'd1;
        if (step == LAST_STEP) begin
          mul_on <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (acc_on) begin
      acc <= result;
    end
    if (mul_on) begin
      prod_r  <= pp;
      shift_r <= (step != 2'd0);
    end
  end

endmodule

@@ rtl/core/pes_store.sv @@
`timescale 1ns / 1ps

module pes_store
  import pes_pkg::*;
#(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic         clk,
  input  pes_mem_ctl_t ctl,
  input  logic [AW-1:0] el_waddr,
  input  logic [W-1:0]  el_wdata,
  input  logic [AW-1:0] el_raddr,
  output logic [W-1:0]  el_rdata,
  input  logic [AW-1:0] ans_waddr,
  input  logic [W-1:0]  ans_wdata,
  input  logic [AW-1:0] ans_raddr,
  output logic [W-1:0]  ans_rdata
);

  logic [W-1:0] el_mem  [DEPTH];
  logic [W-1:0] ans_mem [DEPTH];

  // Read data stays put while no read is issued.
  always_ff @(posedge clk) begin
    if (ctl.el_we) begin
      el_mem[el_waddr] <= el_wdata;
    end
    if (ctl.el_re) begin
      el_rdata <= el_mem[el_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ans_we) begin
      ans_mem[ans_waddr] <= ans_wdata;
    end
    if (ctl.ans_re) begin
      ans_rdata <= ans_mem[ans_raddr];
    end
  end

endmodule

@@ rtl/core/product_except_self_unit.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Payload                                   Transaction
// items     in         value, is_last                            one array element
// results   out        product, is_last_result, overflowed       one answer per position
//
// A non-final element is taken without leaving the idle state. After the final
// element the block runs a forward pass, a backward pass and an output pass,
// all paced by the one shared multiplier and by the registered reads of the
// two memories. Each product takes one partial product for DATA_WIDTH up to
// 32 and three above, where the words are split into halves. Synchronous
// active-high reset clears the sequencer, the fill count, the overflow flag
// and the output valid; the memories hold no reset value. A stalled result
// holds in the output register; new elements are taken as soon as the last
// result of an array is loaded there.

module product_except_self_unit
  import pes_pkg::*;
#(
  parameter int MAX_LEN    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  pes_in_if.sink    items,
  pes_out_if.source results
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0]         MAX_COUNT = CW'(MAX_LEN);
  localparam logic [DATA_WIDTH-1:0] ONE       = DATA_WIDTH'(1);

  typedef enum logic [9:0] {
    IDLE      = 10'b0000000001,
    FWD_RD    = 10'b0000000010,
    FWD_GO    = 10'b0000000100,
    FWD_WAIT  = 10'b0000001000,
    BWD_RD    = 10'b0000010000,
    BWD_SUF   = 10'b0000100000,
    BWD_SWAIT = 10'b0001000000,
    BWD_AWAIT = 10'b0010000000,
    OUT_RD    = 10'b0100000000,
    OUT_LD    = 10'b1000000000
  } state_t;

  state_t state;

  // Array bookkeeping: count and ovf track the array being loaded, n_len and
  // ovf_arr describe the array being worked on.
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] n_len;
  logic          ovf_arr;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] last_idx;
  logic          full;
  logic          accept_in;

  // Running prefix product (forward pass) and suffix product (backward pass).
  logic [DATA_WIDTH-1:0] pre;
  logic [DATA_WIDTH-1:0] suf;

  // Output register.
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] product;
  logic                  is_last_result;
  logic                  overflowed;
  logic                  out_free;

  // Memory and multiplier hookup.
  pes_mem_ctl_t          ctl;
  logic [AW-1:0]         el_waddr;
  logic [AW-1:0]         el_raddr;
  logic [AW-1:0]         ans_waddr;
  logic [AW-1:0]         ans_raddr;
  logic [DATA_WIDTH-1:0] ans_wdata;
  logic [DATA_WIDTH-1:0] el_rdata;
  logic [DATA_WIDTH-1:0] ans_rdata;
  logic                  mul_start;
  logic [DATA_WIDTH-1:0] mul_a;
  logic [DATA_WIDTH-1:0] mul_b;
  logic                  mul_done;
  logic [DATA_WIDTH-1:0] mul_res;

  assign full      = (count == MAX_COUNT);
  assign idx_dec   = idx - CW'(1);
  assign last_idx  = n_len - CW'(1);
  assign accept_in = items.valid && items.ready;
  assign out_free  = !out_valid || results.ready;

  assign items.ready            = (state == IDLE);
  assign results.valid          = out_valid;
  assign results.product        = product;
  assign results.is_last_result = is_last_result;
  assign results.overflowed     = overflowed;

  pes_store #(
    .W     (DATA_WIDTH),
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .el_waddr  (el_waddr),
    .el_wdata  (items.value),
    .el_raddr  (el_raddr),
    .el_rdata  (el_rdata),
    .ans_waddr (ans_waddr),
    .ans_wdata (ans_wdata),
    .ans_raddr (ans_raddr),
    .ans_rdata (ans_rdata)
  );

  pes_mul #(
    .W (DATA_WIDTH)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  // Memory strobes and multiplier operands for each sequencer step.
  always_comb begin
    ctl       = '0;
    el_waddr  = count[AW-1:0];
    el_raddr  = idx[AW-1:0];
    ans_waddr = idx[AW-1:0];
    ans_raddr = idx[AW-1:0];
    ans_wdata = mul_res;
    mul_start = 1'b0;
    mul_a     = pre;
    mul_b     = el_rdata;
    unique case (state)
      IDLE: begin
        // Store the element unless the store is full, and seed the first
        // answer with one at the end of an array.
        ctl.el_we  = accept_in && !full;
        ctl.ans_we = accept_in && items.is_last;
        ans_waddr  = '0;
        ans_wdata  = ONE;
      end
      FWD_RD: begin
        ctl.el_re = 1'b1;
        el_raddr  = idx_dec[AW-1:0];
      end
      FWD_GO: begin
        // The multiplier latches its operands, so the next element can be
        // fetched right away.
        mul_start = 1'b1;
        ctl.el_re = 1'b1;
      end
      FWD_WAIT: begin
        ctl.ans_we = mul_done;
      end
      BWD_RD: begin
        ctl.el_re  = 1'b1;
        ctl.ans_re = 1'b1;
        ans_raddr  = idx_dec[AW-1:0];
      end
      BWD_SUF: begin
        mul_start = 1'b1;
        mul_a     = suf;
      end
      BWD_SWAIT: begin
        // Chain the new suffix product straight into the answer update.
        mul_start = mul_done;
        mul_a     = mul_res;
        mul_b     = ans_rdata;
      end
      BWD_AWAIT: begin
        ctl.ans_we = mul_done;
        ans_waddr  = idx_dec[AW-1:0];
      end
      OUT_RD: begin
        ctl.ans_re = 1'b1;
      end
      OUT_LD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept_in) begin
            if (!full) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (items.is_last) begin
              n_len   <= full ? MAX_COUNT : count + CW'(1);
              ovf_arr <= ovf | full;
              count   <= '0;
              ovf     <= 1'b0;
              pre     <= ONE;
              // A single element needs no passes: its answer is the seed.
              if (full || (count != '0)) begin
                idx   <= CW'(1);
                state <= FWD_RD;
              end else begin
                idx   <= '0;
                state <= OUT_RD;
              end
            end
          end
        end
        FWD_RD: begin
          state <= FWD_GO;
        end
        FWD_GO: begin
          state <= FWD_WAIT;
        end
        FWD_WAIT: begin
          if (mul_done) begin
            pre <= mul_res;
            if (idx == last_idx) begin
              // The backward pass starts at the same top position.
              suf   <= ONE;
              state <= BWD_RD;
            end else begin
              idx   <= idx + CW'(1);
              state <= FWD_GO;
            end
          end
        end
        BWD_RD: begin
          state <= BWD_SUF;
        end
        BWD_SUF: begin
          state <= BWD_SWAIT;
        end
        BWD_SWAIT: begin
          if (mul_done) begin
            suf   <= mul_res;
            state <= BWD_AWAIT;
          end
        end
        BWD_AWAIT: begin
          if (mul_done) begin
            if (idx == CW'(1)) begin
              idx   <= '0;
              state <= OUT_RD;
            end else begin
              idx   <= idx_dec;
              state <= BWD_RD;
            end
          end
        end
        OUT_RD: begin
          state <= OUT_LD;
        end
        OUT_LD: begin
          if (out_free) begin
            product        <= ans_rdata;
            is_last_result <= (idx == last_idx);
            overflowed     <= ovf_arr;
            out_valid      <= 1'b1;
            if (idx == last_idx) begin
              state <= IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= OUT_RD;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/pes_answer_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the product-except-self unit, predicts the answers
// of every finished array and compares each result transaction against them.
module pes_answer_checker #(
  parameter int MAX_LEN    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic                  in_is_last,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [DATA_WIDTH-1:0] out_product,
  input  logic                  out_is_last_result,
  input  logic                  out_overflowed,
  output int                    mismatch_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] product;
    logic                  is_last_result;
    logic                  overflowed;
  } answer_t;

  logic [DATA_WIDTH-1:0] held_elements[$];
  logic                  dropped_any = 1'b0;
  answer_t               expected_answers[$];
  answer_t               oldest;

  // Prefix products first, then a running suffix product folded in from the
  // top end; everything wraps at the data width.
  function automatic void queue_except_products();
    logic [DATA_WIDTH-1:0] partial[MAX_LEN];
    logic [DATA_WIDTH-1:0] run;
    answer_t               ans;
    int                    n;
    n = held_elements.size();
    run = DATA_WIDTH'(1);
    for (int i = 0; i < n; i++) begin
      partial[i] = run;
      run = run * held_elements[i];
    end
    run = DATA_WIDTH'(1);
    for (int i = n - 1; i >= 0; i--) begin
      partial[i] = partial[i] * run;
      run = run * held_elements[i];
    end
    for (int i = 0; i < n; i++) begin
      ans.product        = partial[i];
      ans.is_last_result = (i == n - 1);
      ans.overflowed     = dropped_any;
      expected_answers.push_back(ans);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_elements.delete();
      expected_answers.delete();
      dropped_any    = 1'b0;
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected result: product=%h is_last_result=%b overflowed=%b",
                     out_product, out_is_last_result, out_overflowed);
          end
          mismatch_count++;
        end else begin
          oldest = expected_answers.pop_front();
          if (out_product !== oldest.product || out_is_last_result !== oldest.is_last_result
              || out_overflowed !== oldest.overflowed) begin
            if (mismatch_count < 10) begin
              $display("result mismatch: expected product=%h is_last_result=%b overflowed=%b,",
                       oldest.product, oldest.is_last_result, oldest.overflowed);
              $display("                 actual   product=%h is_last_result=%b overflowed=%b",
                       out_product, out_is_last_result, out_overflowed);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (held_elements.size() < MAX_LEN) begin
          held_elements.push_back(in_value);
        end else begin
          dropped_any = 1'b1;
        end
        if (in_is_last) begin
          queue_except_products();
          held_elements.delete();
          dropped_any = 1'b0;
        end
      end
    end
    pending_count <= expected_answers.size();
  end

endmodule

@@ tb/sv/tb_product_except_self_unit.sv @@
`timescale 1ns / 1ps

// Top of the product-except-self testbench. It builds the clock and reset,
// feeds arrays of elements into the unit and stalls the result channel at
// random. All prediction and comparison lives in the checker instance; this
// module only produces stimulus and decides the verdict at the end.
module tb_product_except_self_unit;

  localparam int MAX_LEN      = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 150;

  // Directed arrays. Bit 32 of each entry is the end-of-array flag. They cover
  // one-element arrays (which must give 1), the most negative and most
  // positive values, all-ones, a single zero, two zeros and products that
  // wrap around the data width.
  localparam logic [32:0] DIRECTED_ITEMS[22] = '{
    {1'b1, 32'h8000_0000},
    {1'b1, 32'h0000_0000},
    {1'b0, 32'h7FFF_FFFF}, {1'b1, 32'h8000_0000},
    {1'b0, 32'hFFFF_FFFF}, {1'b0, 32'hFFFF_FFFF}, {1'b1, 32'hFFFF_FFFF},
    {1'b0, 32'h0000_0002}, {1'b0, 32'h0000_0000}, {1'b1, 32'h0000_0005},
    {1'b0, 32'h0000_0000}, {1'b0, 32'h0000_0003}, {1'b1, 32'h0000_0000},
    {1'b0, 32'h7FFF_FFFF}, {1'b0, 32'h7FFF_FFFF}, {1'b0, 32'h7FFF_FFFF},
    {1'b1, 32'h0000_0003},
    {1'b0, 32'h0000_0001}, {1'b0, 32'h0000_0002}, {1'b0, 32'h0000_0003},
    {1'b0, 32'h0000_0004}, {1'b1, 32'h0000_0005}
  };

  logic clk = 1'b0;
  logic rst;
  bit   idle_on = 1'b1;
  int   stall_left = 0;
  int   mismatch_count;
  int   pending_count;
  int   random_sent;
  int   array_index;
  int   array_len;

  pes_in_if  #(.DATA_WIDTH(DATA_WIDTH)) items ();
  pes_out_if #(.DATA_WIDTH(DATA_WIDTH)) results ();

  product_except_self_unit #(
    .MAX_LEN   (MAX_LEN),
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .results(results)
  );

  pes_answer_checker #(
    .MAX_LEN   (MAX_LEN),
    .DATA_WIDTH(DATA_WIDTH)
  ) answer_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (items.valid),
    .in_ready          (items.ready),
    .in_value          (items.value),
    .in_is_last        (items.is_last),
    .out_valid         (results.valid),
    .out_ready         (results.ready),
    .out_product       (results.product),
    .out_is_last_result(results.is_last_result),
    .out_overflowed    (results.overflowed),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The result side stalls in random bursts. Once idling is
  // switched off near the end, ready stays high for good after the current
  // burst runs out.
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (stall_left != 0) begin
      results.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      results.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 6);
    end else begin
      results.ready <= 1'b1;
    end
  end

  // Element values are weighted: full random patterns exercise every bit,
  // odd values keep long products from collapsing to zero, small values and
  // the extremes hit sign changes and wrap-around.
  function automatic logic [DATA_WIDTH-1:0] pick_value();
    logic [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom();
      2, 3: v = $urandom() | 32'h1;
      4, 5: v = $urandom_range(0, 8) - 4;
      6: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h0000_0000;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
    endcase
    return v;
  endfunction

  // Present one element and hold it until the unit takes the transaction.
  // A random gap of idle cycles may come first. Called right at a
  // rising edge, so valid gets exactly one update in that time step.
  task automatic send_element(input logic [DATA_WIDTH-1:0] v, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    items.valid   <= 1'b1;
    items.value   <= v;
    items.is_last <= last;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    items.valid   = 1'b0;
    items.value   = '0;
    items.is_last = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ITEMS[i]) begin
      send_element(DIRECTED_ITEMS[i][31:0], DIRECTED_ITEMS[i][32]);
    end

    // Random arrays, mostly short. The third array always runs past MAX_LEN
    // with its end flag on a dropped element, and the sixth fills the store
    // exactly; now and then another long or overflowing array shows up.
    random_sent = 0;
    array_index = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (array_index == 2) begin
        array_len = MAX_LEN + $urandom_range(1, 5);
      end else if (array_index == 5) begin
        array_len = MAX_LEN;
      end else begin
        case ($urandom_range(0, 19))
          0: array_len = MAX_LEN + $urandom_range(1, 4);
          1: array_len = $urandom_range(20, MAX_LEN);
          default: array_len = $urandom_range(1, 8);
        endcase
      end
      for (int k = 0; k < array_len; k++) begin
        send_element(pick_value(), k == array_len - 1);
        random_sent++;
        // The last part of the run goes at full rate on both sides.
        if (random_sent > RANDOM_ITEMS * 5 / 6) idle_on = 1'b0;
      end
      array_index++;
    end

    // The final element was taken at this edge; the checker has queued its
    // answers by the next one.
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
